// File: hw/rtl/gdfa_pkg.sv
// gdfa_pkg: shared types and constants of the gaussian density and flow accumulator
// register indexes, reset values, flow limits, sequencer codes and the multiplier request
// no dependencies
package gdfa_pkg;

  // configuration register indexes
  localparam logic [1:0] REG_CENTER_X   = 2'd0;
  localparam logic [1:0] REG_CENTER_Y   = 2'd1;
  localparam logic [1:0] REG_INV_RAD_SQ = 2'd2;
  localparam logic [1:0] REG_PEAK       = 2'd3;

  localparam logic [15:0] CENTER_X_RST   = 16'd3584;
  localparam logic [15:0] CENTER_Y_RST   = 16'd896;
  localparam logic [15:0] INV_RAD_SQ_RST = 16'd256;
  localparam logic [15:0] PEAK_RST       = 16'd5215;

  localparam logic signed [47:0] FLOW_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] FLOW_MIN = 48'sh8000_0000_0000;

  // sequencer codes
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DXX    = 4'd1;
  localparam logic [3:0] S_DYY    = 4'd2;
  localparam logic [3:0] S_SUM    = 4'd3;
  localparam logic [3:0] S_SCALE  = 4'd4;
  localparam logic [3:0] S_INDEX  = 4'd5;
  localparam logic [3:0] S_LOOKUP = 4'd6;
  localparam logic [3:0] S_WEIGHT = 4'd7;
  localparam logic [3:0] S_ROUND  = 4'd8;
  localparam logic [3:0] S_FLOWX  = 4'd9;
  localparam logic [3:0] S_FLOWY  = 4'd10;
  localparam logic [3:0] S_FINISH = 4'd11;

  localparam int unsigned MUL_A_W = 34;
  localparam int unsigned MUL_B_W = 18;
  localparam int unsigned PROD_W  = MUL_A_W + MUL_B_W;

  typedef struct packed {
    logic                      en;
    logic signed [MUL_A_W-1:0] a;
    logic signed [MUL_B_W-1:0] b;
  } mul_req_t;

endpackage

// File: hw/rtl/gdfa_in_if.sv
// gdfa_in_if: particle request channel, valid/ready with position, velocity
// and frame-end mark
// no dependencies
interface gdfa_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic signed [15:0] vel_x;
  logic signed [15:0] vel_y;
  logic               frame_last;

  modport source(output valid, pos_x, pos_y, vel_x, vel_y, frame_last, input ready);
  modport sink(input valid, pos_x, pos_y, vel_x, vel_y, frame_last, output ready);
endinterface

// File: hw/rtl/gdfa_out_if.sv
// gdfa_out_if: frame result channel, valid/ready with the four frame sums
// no dependencies
interface gdfa_out_if;
  logic               valid;
  logic               ready;
  logic        [31:0] density_sum;
  logic signed [47:0] flow_x_sum;
  logic signed [47:0] flow_y_sum;
  logic        [15:0] particle_count;

  modport source(output valid, density_sum, flow_x_sum, flow_y_sum, particle_count,
                 input ready);
  modport sink(input valid, density_sum, flow_x_sum, flow_y_sum, particle_count,
               output ready);
endinterface

// File: hw/rtl/gaussian_density_flow_accumulator.sv
// gaussian_density_flow_accumulator: top level, sequencer, config registers and
// saturating frame accumulators around one shared multiplier and the exp table
// depends on gdfa_pkg, gdfa_in_if, gdfa_out_if, gdfa_mul_unit, gdfa_exp_rom
//
//   channel    dir  handshake      payload
//   item_i     in   valid/ready    pos_x, pos_y, vel_x, vel_y, frame_last
//   result_o   out  valid/ready    density_sum, flow_x_sum, flow_y_sum, particle_count
//   cfg        in   cfg_we_i       cfg_idx_i, cfg_data_i
//
// one particle at a time: the accept plus 11 sequencer steps, set by
// seven dependent products through the one multiplier and the registered table read
// ready is high only while the sequencer idles
// a frame result sits in the output register; a final particle waits in its last
// step only while a previous result has not been taken
// reset clears config to defaults, accumulators to zero and the output valid
module gaussian_density_flow_accumulator
  import gdfa_pkg::*;
#(
  parameter int unsigned EXP_TABLE_ENTRIES = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  gdfa_in_if.sink     item_i,
  gdfa_out_if.source  result_o
);

  localparam int unsigned IdxW = $clog2(EXP_TABLE_ENTRIES);

  // config registers
  logic signed [15:0] center_x_q, center_y_q;
  logic        [15:0] inv_rad_sq_q, peak_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q   <= CENTER_X_RST;
      center_y_q   <= CENTER_Y_RST;
      inv_rad_sq_q <= INV_RAD_SQ_RST;
      peak_q       <= PEAK_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_CENTER_X:   center_x_q   <= cfg_data_i;
        REG_CENTER_Y:   center_y_q   <= cfg_data_i;
        REG_INV_RAD_SQ: inv_rad_sq_q <= cfg_data_i;
        REG_PEAK:       peak_q       <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // sequencer and datapath registers
  logic [3:0]         state_q, state_d;
  logic signed [16:0] dx_q, dy_q;
  logic signed [15:0] vel_x_q, vel_y_q;
  logic               last_q;
  logic [32:0]        d2_q;
  logic               far_q;
  logic [15:0]        w_q;

  logic [31:0]        density_q;
  logic signed [47:0] flow_x_q, flow_y_q;
  logic [15:0]        count_q;

  logic               out_valid_q;
  logic [31:0]        out_density_q;
  logic signed [47:0] out_flow_x_q, out_flow_y_q;
  logic [15:0]        out_count_q;

  mul_req_t                 mul_req;
  logic signed [PROD_W-1:0] prod;
  logic                     rom_en;
  logic [15:0]              rom_data;
  logic [15:0]              exp_val;
  logic [31:0]              round_sum;
  logic [32:0]              dens_sum;
  logic [31:0]              dens_sat;
  logic signed [47:0]       flow_x_sat, flow_y_sat;
  logic [15:0]              count_inc;
  logic                     accept;
  logic                     finish_go;
  logic                     emit;

  function automatic logic signed [47:0] flow_add(logic signed [47:0] acc,
                                                  logic signed [48:0] p);
    logic signed [48:0] s;
    s = {acc[47], acc} + p;
    if (s[48] != s[47]) begin
      return s[48] ? FLOW_MIN : FLOW_MAX;
    end
    return s[47:0];
  endfunction

  assign item_i.ready = (state_q == S_IDLE);
  assign accept       = item_i.valid && item_i.ready;
  // last step of a final particle must find the output register free
  assign finish_go    = (state_q == S_FINISH) &&
                        (!last_q || !out_valid_q || result_o.ready);
  assign emit         = finish_go && last_q;

  assign exp_val    = far_q ? 16'd0 : rom_data;
  assign round_sum  = prod[31:0] + 32'd32768;
  assign dens_sum   = {1'b0, density_q} + {17'd0, w_q};
  assign dens_sat   = dens_sum[32] ? 32'hFFFF_FFFF : dens_sum[31:0];
  assign flow_x_sat = flow_add(flow_x_q, prod[48:0]);
  assign flow_y_sat = flow_add(flow_y_q, prod[48:0]);
  assign count_inc  = (count_q == 16'hFFFF) ? count_q : count_q + 16'd1;
  assign rom_en     = (state_q == S_LOOKUP);

  always_comb begin
    state_d   = state_q;
    mul_req   = '{en: 1'b0, a: '0, b: '0};
    case (state_q)
      S_IDLE:   if (accept) state_d = S_DXX;
      S_DXX: begin
        mul_req = '{en: 1'b1, a: MUL_A_W'(dx_q), b: MUL_B_W'(dx_q)};
        state_d = S_DYY;
      end
      S_DYY: begin
        mul_req = '{en: 1'b1, a: MUL_A_W'(dy_q), b: MUL_B_W'(dy_q)};
        state_d = S_SUM;
      end
      S_SUM:    state_d = S_SCALE;
      S_SCALE: begin
        mul_req = '{en: 1'b1, a: {1'b0, d2_q}, b: {2'b00, inv_rad_sq_q}};
        state_d = S_INDEX;
      end
      S_INDEX: begin
        // table index = fraction below 16.0 scaled by the entry count
        mul_req = '{en: 1'b1, a: {6'd0, prod[27:0]}, b: MUL_B_W'(EXP_TABLE_ENTRIES)};
        state_d = S_LOOKUP;
      end
      S_LOOKUP: state_d = S_WEIGHT;
      S_WEIGHT: begin
        mul_req = '{en: 1'b1, a: {18'd0, peak_q}, b: {2'b00, exp_val}};
        state_d = S_ROUND;
      end
      S_ROUND:  state_d = S_FLOWX;
      S_FLOWX: begin
        mul_req = '{en: 1'b1, a: {18'd0, w_q}, b: {{2{vel_x_q[15]}}, vel_x_q}};
        state_d = S_FLOWY;
      end
      S_FLOWY: begin
        mul_req = '{en: 1'b1, a: {18'd0, w_q}, b: {{2{vel_y_q[15]}}, vel_y_q}};
        state_d = S_FINISH;
      end
      S_FINISH: if (finish_go) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      density_q   <= '0;
      flow_x_q    <= '0;
      flow_y_q    <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == S_FLOWX) begin
        density_q <= dens_sat;
      end
      if (state_q == S_FLOWY) begin
        flow_x_q <= flow_x_sat;
      end
      if (finish_go) begin
        if (last_q) begin
          out_valid_q <= 1'b1;
          density_q   <= '0;
          flow_x_q    <= '0;
          flow_y_q    <= '0;
          count_q     <= '0;
        end else begin
          flow_y_q <= flow_y_sat;
          count_q  <= count_inc;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      dx_q    <= {item_i.pos_x[15], item_i.pos_x} - {center_x_q[15], center_x_q};
      dy_q    <= {item_i.pos_y[15], item_i.pos_y} - {center_y_q[15], center_y_q};
      vel_x_q <= item_i.vel_x;
      vel_y_q <= item_i.vel_y;
      last_q  <= item_i.frame_last;
    end
    if (state_q == S_DYY) begin
      d2_q <= prod[32:0];
    end
    if (state_q == S_SUM) begin
      d2_q <= d2_q + prod[32:0];
    end
    if (state_q == S_INDEX) begin
      far_q <= (prod[PROD_W-1:28] != '0);
    end
    if (state_q == S_ROUND) begin
      w_q <= round_sum[31:16];
    end
    if (emit) begin
      out_density_q <= density_q;
      out_flow_x_q  <= flow_x_q;
      out_flow_y_q  <= flow_y_sat;
      out_count_q   <= count_inc;
    end
  end

  gdfa_mul_unit u_mul (
    .clk_i  (clk_i),
    .req_i  (mul_req),
    .prod_o (prod)
  );

  gdfa_exp_rom #(
    .Entries (EXP_TABLE_ENTRIES)
  ) u_exp_rom (
    .clk_i     (clk_i),
    .rd_en_i   (rom_en),
    .rd_addr_i (prod[28 +: IdxW]),
    .rd_data_o (rom_data)
  );

  assign result_o.valid          = out_valid_q;
  assign result_o.density_sum    = out_density_q;
  assign result_o.flow_x_sum     = out_flow_x_q;
  assign result_o.flow_y_sum     = out_flow_y_q;
  assign result_o.particle_count = out_count_q;

  // a result appears only out of the last step of a final particle
  a_emit_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_FINISH && last_q))
    else $error("result raised outside final particle step");

  // sums are empty right after a frame is emitted
  a_clear_after_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> (count_q == '0 && density_q == '0 && flow_x_q == '0 && flow_y_q == '0))
    else $error("accumulators not cleared after frame result");

  // a pending result is never overwritten
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !result_o.ready) |-> !emit)
    else $error("frame result overwritten while pending");

  // particle count saturates and only restarts on a frame end
  a_count_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == 16'hFFFF && !emit) |=> count_q == 16'hFFFF)
    else $error("particle count wrapped");

endmodule

// File: hw/rtl/gdfa_exp_rom.sv
// gdfa_exp_rom: exp(-16k/Entries) table in unsigned Q0.16, built at elaboration
// registered read port
// no dependencies
module gdfa_exp_rom #(
  parameter int unsigned Entries = 256
) (
  input  logic                       clk_i,
  input  logic                       rd_en_i,
  input  logic [$clog2(Entries)-1:0] rd_addr_i,
  output logic [15:0]                rd_data_o
);

  typedef logic [15:0] rom_t [Entries];

  // step ratio exponent h = 16/Entries in Q0.32
  localparam logic [63:0] StepH = (64'd1 << 36) / Entries;

  function automatic rom_t build_rom();
    rom_t               t;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic [63:0]        r;
    logic [63:0]        v;
    logic [63:0]        q;
    term = 64'd1 << 32;
    sum  = 64'sd4294967296;
    for (int n = 1; n <= 14; n++) begin
      term = ((term * StepH) >> 32) / 64'(n);
      if (n % 2 == 1) begin
        sum = sum - $signed(term);
      end else begin
        sum = sum + $signed(term);
      end
    end
    r = $unsigned(sum);
    v = 64'd1 << 32;
    for (int k = 0; k < int'(Entries); k++) begin
      if (k > 0) begin
        v = (v * r + (64'd1 << 31)) >> 32;
      end
      q = (v + 64'd32768) >> 16;
      t[k] = (q > 64'd65535) ? 16'hFFFF : q[15:0];
    end
    return t;
  endfunction

  localparam rom_t ExpRom = build_rom();

  logic [15:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= ExpRom[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: hw/rtl/gdfa_mul_unit.sv
// gdfa_mul_unit: shared signed 34 x 18 multiplier with registered product
// depends on gdfa_pkg
module gdfa_mul_unit
  import gdfa_pkg::*;
(
  input  logic                     clk_i,
  input  mul_req_t                 req_i,
  output logic signed [PROD_W-1:0] prod_o
);

  logic signed [MUL_A_W-1:0] op_a;
  logic signed [MUL_B_W-1:0] op_b;
  logic signed [PROD_W-1:0]  prod_d;
  logic signed [PROD_W-1:0]  prod_q;

  assign op_a   = req_i.a;
  assign op_b   = req_i.b;
  assign prod_d = PROD_W'(op_a) * PROD_W'(op_b);

  always_ff @(posedge clk_i) begin
    if (req_i.en) begin
      prod_q <= prod_d;
    end
  end

  assign prod_o = prod_q;

endmodule
